// ===== src/qru_pkg.sv =====
package qru_pkg;

  localparam int Q_W   = 16;
  localparam int IO_W  = 24;
  localparam int A_W   = 42;
  localparam int B_W   = 17;
  localparam int P_W   = A_W + B_W;
  localparam int T_W   = 42;
  localparam int ACC_W = 62;

  localparam logic [2:0] ACT_IDENT = 3'd0;
  localparam logic [2:0] ACT_INT   = 3'd1;
  localparam logic [2:0] ACT_ROT   = 3'd2;
  localparam logic [2:0] ACT_REV   = 3'd3;
  localparam logic [2:0] ACT_MAT   = 3'd4;

  // operand a selects
  localparam logic [3:0] OA_A0 = 4'd0;
  localparam logic [3:0] OA_A1 = 4'd1;
  localparam logic [3:0] OA_A2 = 4'd2;
  localparam logic [3:0] OA_T0 = 4'd3;
  localparam logic [3:0] OA_T1 = 4'd4;
  localparam logic [3:0] OA_T2 = 4'd5;
  localparam logic [3:0] OA_T3 = 4'd6;
  localparam logic [3:0] OA_QW = 4'd7;
  localparam logic [3:0] OA_QX = 4'd8;
  localparam logic [3:0] OA_QY = 4'd9;
  localparam logic [3:0] OA_QZ = 4'd10;

  // operand b selects
  localparam logic [2:0] OB_QW = 3'd0;
  localparam logic [2:0] OB_QX = 3'd1;
  localparam logic [2:0] OB_QY = 3'd2;
  localparam logic [2:0] OB_QZ = 3'd3;
  localparam logic [2:0] OB_UX = 3'd4;
  localparam logic [2:0] OB_UY = 3'd5;
  localparam logic [2:0] OB_UZ = 3'd6;

  localparam logic Y = 1'b1;
  localparam logic N = 1'b0;

  localparam logic [4:0] ROT_LAST_STEP = 5'd23;

  typedef struct packed {
    logic [2:0]             action;
    logic signed [IO_W-1:0] in_x;
    logic signed [IO_W-1:0] in_y;
    logic signed [IO_W-1:0] in_z;
  } in_t;

  typedef struct packed {
    logic signed [IO_W-1:0] out_x;
    logic signed [IO_W-1:0] out_y;
    logic signed [IO_W-1:0] out_z;
    logic                   last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RUN, S_DRAIN, S_EMIT, S_UPD
  } state_t;

  typedef enum logic [1:0] {
    K_INT, K_ROT, K_MAT
  } kind_t;

  typedef struct packed {
    logic [3:0] asel;
    logic [2:0] bsel;
    logic       neg;
    logic       first;
    logic       one;
    logic       last;
    logic       to_t;
    logic [1:0] dest;
    logic       emit;
    logic       fin;
  } uop_t;

  typedef struct packed {
    logic                    valid;
    logic                    to_t;
    logic [1:0]              dest;
    logic signed [ACC_W-1:0] value;
  } wb_t;

  function automatic uop_t mk(logic [3:0] a, logic [2:0] b, logic ng, logic fs, logic on,
                              logic ls, logic tt, logic [1:0] ds, logic em, logic fn);
    uop_t u;
    u.asel  = a;
    u.bsel  = b;
    u.neg   = ng;
    u.first = fs;
    u.one   = on;
    u.last  = ls;
    u.to_t  = tt;
    u.dest  = ds;
    u.emit  = em;
    u.fin   = fn;
    return u;
  endfunction

  // microprogram: one product per step
  function automatic uop_t prog(kind_t k, logic [4:0] s);
    uop_t u;
    u = '0;
    unique case (k)
      K_INT: begin
        case (s)
          5'd0:  u = mk(OA_A0, OB_QX, Y, Y, N, N, Y, 2'd0, N, N);
          5'd1:  u = mk(OA_A1, OB_QY, Y, N, N, N, Y, 2'd0, N, N);
          5'd2:  u = mk(OA_A2, OB_QZ, Y, N, N, Y, Y, 2'd0, N, N);
          5'd3:  u = mk(OA_A0, OB_QW, N, Y, N, N, Y, 2'd1, N, N);
          5'd4:  u = mk(OA_A1, OB_QZ, N, N, N, N, Y, 2'd1, N, N);
          5'd5:  u = mk(OA_A2, OB_QY, Y, N, N, Y, Y, 2'd1, N, N);
          5'd6:  u = mk(OA_A1, OB_QW, N, Y, N, N, Y, 2'd2, N, N);
          5'd7:  u = mk(OA_A2, OB_QX, N, N, N, N, Y, 2'd2, N, N);
          5'd8:  u = mk(OA_A0, OB_QZ, Y, N, N, Y, Y, 2'd2, N, N);
          5'd9:  u = mk(OA_A2, OB_QW, N, Y, N, N, Y, 2'd3, N, N);
          5'd10: u = mk(OA_A0, OB_QY, N, N, N, N, Y, 2'd3, N, N);
          5'd11: u = mk(OA_A1, OB_QX, Y, N, N, Y, Y, 2'd3, N, Y);
          default: u = '0;
        endcase
      end
      K_ROT: begin
        case (s)
          5'd0:  u = mk(OA_A0, OB_UX, Y, Y, N, N, Y, 2'd0, N, N);
          5'd1:  u = mk(OA_A1, OB_UY, Y, N, N, N, Y, 2'd0, N, N);
          5'd2:  u = mk(OA_A2, OB_UZ, Y, N, N, Y, Y, 2'd0, N, N);
          5'd3:  u = mk(OA_A0, OB_QW, N, Y, N, N, Y, 2'd1, N, N);
          5'd4:  u = mk(OA_A2, OB_UY, N, N, N, N, Y, 2'd1, N, N);
          5'd5:  u = mk(OA_A1, OB_UZ, Y, N, N, Y, Y, 2'd1, N, N);
          5'd6:  u = mk(OA_A1, OB_QW, N, Y, N, N, Y, 2'd2, N, N);
          5'd7:  u = mk(OA_A0, OB_UZ, N, N, N, N, Y, 2'd2, N, N);
          5'd8:  u = mk(OA_A2, OB_UX, Y, N, N, Y, Y, 2'd2, N, N);
          5'd9:  u = mk(OA_A2, OB_QW, N, Y, N, N, Y, 2'd3, N, N);
          5'd10: u = mk(OA_A1, OB_UX, N, N, N, N, Y, 2'd3, N, N);
          5'd11: u = mk(OA_A0, OB_UY, Y, N, N, Y, Y, 2'd3, N, N);
          5'd12: u = mk(OA_T0, OB_UX, Y, Y, N, N, N, 2'd0, N, N);
          5'd13: u = mk(OA_T1, OB_QW, N, N, N, N, N, 2'd0, N, N);
          5'd14: u = mk(OA_T2, OB_UZ, Y, N, N, N, N, 2'd0, N, N);
          5'd15: u = mk(OA_T3, OB_UY, N, N, N, Y, N, 2'd0, N, N);
          5'd16: u = mk(OA_T0, OB_UY, Y, Y, N, N, N, 2'd1, N, N);
          5'd17: u = mk(OA_T2, OB_QW, N, N, N, N, N, 2'd1, N, N);
          5'd18: u = mk(OA_T3, OB_UX, Y, N, N, N, N, 2'd1, N, N);
          5'd19: u = mk(OA_T1, OB_UZ, N, N, N, Y, N, 2'd1, N, N);
          5'd20: u = mk(OA_T0, OB_UZ, Y, Y, N, N, N, 2'd2, N, N);
          5'd21: u = mk(OA_T3, OB_QW, N, N, N, N, N, 2'd2, N, N);
          5'd22: u = mk(OA_T1, OB_UY, Y, N, N, N, N, 2'd2, N, N);
          5'd23: u = mk(OA_T2, OB_UX, N, N, N, Y, N, 2'd2, Y, Y);
          default: u = '0;
        endcase
      end
      K_MAT: begin
        case (s)
          5'd0:  u = mk(OA_QY, OB_QY, Y, Y, Y, N, N, 2'd0, N, N);
          5'd1:  u = mk(OA_QZ, OB_QZ, Y, N, N, Y, N, 2'd0, N, N);
          5'd2:  u = mk(OA_QX, OB_QY, N, Y, N, N, N, 2'd1, N, N);
          5'd3:  u = mk(OA_QZ, OB_QW, N, N, N, Y, N, 2'd1, N, N);
          5'd4:  u = mk(OA_QX, OB_QZ, N, Y, N, N, N, 2'd2, N, N);
          5'd5:  u = mk(OA_QY, OB_QW, Y, N, N, Y, N, 2'd2, Y, N);
          5'd6:  u = mk(OA_QX, OB_QY, N, Y, N, N, N, 2'd0, N, N);
          5'd7:  u = mk(OA_QZ, OB_QW, Y, N, N, Y, N, 2'd0, N, N);
          5'd8:  u = mk(OA_QX, OB_QX, Y, Y, Y, N, N, 2'd1, N, N);
          5'd9:  u = mk(OA_QZ, OB_QZ, Y, N, N, Y, N, 2'd1, N, N);
          5'd10: u = mk(OA_QY, OB_QZ, N, Y, N, N, N, 2'd2, N, N);
          5'd11: u = mk(OA_QX, OB_QW, N, N, N, Y, N, 2'd2, Y, N);
          5'd12: u = mk(OA_QX, OB_QZ, N, Y, N, N, N, 2'd0, N, N);
          5'd13: u = mk(OA_QY, OB_QW, N, N, N, Y, N, 2'd0, N, N);
          5'd14: u = mk(OA_QY, OB_QZ, N, Y, N, N, N, 2'd1, N, N);
          5'd15: u = mk(OA_QX, OB_QW, Y, N, N, Y, N, 2'd1, N, N);
          5'd16: u = mk(OA_QX, OB_QX, Y, Y, Y, N, N, 2'd2, N, N);
          5'd17: u = mk(OA_QY, OB_QY, Y, N, N, Y, N, 2'd2, Y, Y);
          default: u = '0;
        endcase
      end
      default: u = '0;
    endcase
    return u;
  endfunction

endpackage

// ===== src/qru_mac.sv =====
module qru_mac import qru_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    issue,
  input  uop_t                    uop,
  input  logic                    dbl,
  input  logic signed [ACC_W-1:0] one_val,
  input  logic signed [A_W-1:0]   a_op,
  input  logic signed [B_W-1:0]   b_op,
  output wb_t                     wb
);

  logic signed [P_W-1:0]   prod;
  logic signed [P_W-1:0]   p_r;
  uop_t                    c_r;
  logic                    v_r;
  logic                    dbl_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] pe;
  logic signed [ACC_W-1:0] base;

  assign prod = a_op * b_op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= issue;
    end
    p_r   <= prod;
    c_r   <= uop;
    dbl_r <= dbl;
    if (v_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    pe = ACC_W'(p_r);
    if (dbl_r) begin
      pe = pe <<< 1;
    end
    if (c_r.first) begin
      base = c_r.one ? one_val : '0;
    end else begin
      base = acc_r;
    end
    acc_nxt = c_r.neg ? base - pe : base + pe;
  end

  assign wb.valid = v_r && c_r.last;
  assign wb.to_t  = c_r.to_t;
  assign wb.dest  = c_r.dest;
  assign wb.value = acc_nxt;

endmodule

// ===== src/quaternion_rotation_unit.sv =====
// Quaternion rotation unit: holds one orientation quaternion (w, x, y, z),
// 16-bit signed with FRAC_BITS fraction bits, and runs one request at a time.
// Input channel in_valid / in_stall / in_data: action 0 sets identity,
// 1 integrates an angular increment, 2 rotates a vector, 3 rotates in
// reverse, 4 reads the rotation matrix; codes 5 to 7 are dropped.
// Output channel out_valid / out_stall / out_data: one result per rotation,
// three row results for a matrix read, last set on the final one.
// All products go through one multiplier feeding one accumulator under a
// microprogrammed sequencer, one product per cycle while it runs:
//   identity and unused codes: taken in the accept cycle, no busy time
//   integrate: 12 products, then the quaternion update
//   rotate: 24 products, then the result goes to the output register
//   matrix: 18 products, six per row, each row to the output register
// in_stall stays high while a request is in work. A stalled receiver holds
// the output register; the sequencer waits until it is free before writing
// the next result, and the block returns to idle with a result still waiting.
// Reset sets the quaternion to identity and empties the output register.
module quaternion_rotation_unit import qru_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam logic signed [Q_W-1:0] IDENT_W = (FRAC_BITS >= Q_W - 1) ?
    {1'b0, {(Q_W-1){1'b1}}} : Q_W'(1 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0] ONE    = ACC_W'(1) << (2 * FRAC_BITS);
  localparam logic signed [ACC_W-1:0] HALF_F = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] HALF_2 = ACC_W'(1) << (2 * FRAC_BITS - 1);
  localparam logic signed [T_W:0]     HALF_I = (T_W+1)'(1) << FRAC_BITS;
  localparam logic signed [IO_W-1:0]  IO_MAX = {1'b0, {(IO_W-1){1'b1}}};
  localparam logic signed [IO_W-1:0]  IO_MIN = {1'b1, {(IO_W-1){1'b0}}};
  localparam logic signed [Q_W-1:0]   Q_MAX  = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0]   Q_MIN  = {1'b1, {(Q_W-1){1'b0}}};

  state_t                  state_r, state_nxt;
  kind_t                   kind_r;
  logic [4:0]              step_r, step_nxt;
  logic                    em_r, fn_r;
  logic signed [Q_W-1:0]   q_r [4];
  logic signed [IO_W-1:0]  a_r [3];
  logic signed [B_W-1:0]   u_r [3];
  logic signed [T_W-1:0]   t_r [4];
  logic signed [ACC_W-1:0] r_r [3];
  logic                    out_valid_r;
  out_t                    out_r, out_nxt;
  logic signed [Q_W-1:0]   q_upd [4];

  uop_t                    uop;
  logic                    issue;
  logic                    accept;
  logic                    out_free;
  logic signed [A_W-1:0]   a_op;
  logic signed [B_W-1:0]   b_op;
  wb_t                     wb;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign issue    = (state_r == S_RUN);
  assign uop      = prog(kind_r, step_r);

  always_comb begin
    unique case (uop.asel)
      OA_A0:   a_op = A_W'(a_r[0]);
      OA_A1:   a_op = A_W'(a_r[1]);
      OA_A2:   a_op = A_W'(a_r[2]);
      OA_T0:   a_op = A_W'(t_r[0]);
      OA_T1:   a_op = A_W'(t_r[1]);
      OA_T2:   a_op = A_W'(t_r[2]);
      OA_T3:   a_op = A_W'(t_r[3]);
      OA_QW:   a_op = A_W'(q_r[0]);
      OA_QX:   a_op = A_W'(q_r[1]);
      OA_QY:   a_op = A_W'(q_r[2]);
      OA_QZ:   a_op = A_W'(q_r[3]);
      default: a_op = '0;
    endcase
    unique case (uop.bsel)
      OB_QW:   b_op = B_W'(q_r[0]);
      OB_QX:   b_op = B_W'(q_r[1]);
      OB_QY:   b_op = B_W'(q_r[2]);
      OB_QZ:   b_op = B_W'(q_r[3]);
      OB_UX:   b_op = u_r[0];
      OB_UY:   b_op = u_r[1];
      OB_UZ:   b_op = u_r[2];
      default: b_op = '0;
    endcase
  end

  qru_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .issue   (issue),
    .uop     (uop),
    .dbl     (kind_r == K_MAT),
    .one_val (ONE),
    .a_op    (a_op),
    .b_op    (b_op),
    .wb      (wb)
  );

  function automatic logic signed [IO_W-1:0] sat_io(logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(IO_MAX)) return IO_MAX;
    if (v < ACC_W'(IO_MIN)) return IO_MIN;
    return v[IO_W-1:0];
  endfunction

  // round half up to the output scale, then clamp
  always_comb begin
    logic signed [ACC_W-1:0] rs [3];
    for (int k = 0; k < 3; k++) begin
      if (kind_r == K_ROT) begin
        rs[k] = (r_r[k] + HALF_2) >>> (2 * FRAC_BITS);
      end else begin
        rs[k] = (r_r[k] + HALF_F) >>> FRAC_BITS;
      end
    end
    out_nxt.out_x = sat_io(rs[0]);
    out_nxt.out_y = sat_io(rs[1]);
    out_nxt.out_z = sat_io(rs[2]);
    out_nxt.last  = fn_r;
  end

  // q + 0.5 * d, d held in t with twice the fraction bits
  always_comb begin
    logic signed [T_W:0] d;
    logic signed [T_W:0] s;
    for (int k = 0; k < 4; k++) begin
      d = ((T_W+1)'(t_r[k]) + HALF_I) >>> (FRAC_BITS + 1);
      s = d + (T_W+1)'(q_r[k]);
      if (s > (T_W+1)'(Q_MAX)) begin
        q_upd[k] = Q_MAX;
      end else if (s < (T_W+1)'(Q_MIN)) begin
        q_upd[k] = Q_MIN;
      end else begin
        q_upd[k] = s[Q_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        if (accept && (in_data.action == ACT_INT || in_data.action == ACT_ROT ||
                       in_data.action == ACT_REV || in_data.action == ACT_MAT)) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        step_nxt = step_r + 5'd1;
        if (uop.emit || uop.fin) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = em_r ? S_EMIT : S_UPD;
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = fn_r ? S_IDLE : S_RUN;
        end
      end
      S_UPD: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      q_r[0]      <= IDENT_W;
      q_r[1]      <= '0;
      q_r[2]      <= '0;
      q_r[3]      <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (accept && in_data.action == ACT_IDENT) begin
        q_r[0] <= IDENT_W;
        q_r[1] <= '0;
        q_r[2] <= '0;
        q_r[3] <= '0;
      end else if (state_r == S_UPD) begin
        for (int k = 0; k < 4; k++) begin
          q_r[k] <= q_upd[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_r[0] <= in_data.in_x;
      a_r[1] <= in_data.in_y;
      a_r[2] <= in_data.in_z;
      for (int k = 0; k < 3; k++) begin
        u_r[k] <= (in_data.action == ACT_REV) ? -B_W'(q_r[k+1]) : B_W'(q_r[k+1]);
      end
      if (in_data.action == ACT_INT) begin
        kind_r <= K_INT;
      end else if (in_data.action == ACT_MAT) begin
        kind_r <= K_MAT;
      end else begin
        kind_r <= K_ROT;
      end
    end
    if (state_r == S_RUN && (uop.emit || uop.fin)) begin
      em_r <= uop.emit;
      fn_r <= uop.fin;
    end
    if (wb.valid) begin
      if (wb.to_t) begin
        t_r[wb.dest] <= wb.value[T_W-1:0];
      end else begin
        r_r[wb.dest] <= wb.value;
      end
    end
    if (state_r == S_EMIT && out_free) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_rot_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.action == ACT_ROT || in_data.action == ACT_REV) |=> in_stall)
    else $error("rotation request did not start the sequencer");

  a_no_wb_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> !wb.valid)
    else $error("accumulator write while a result is pending");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> step_r <= ROT_LAST_STEP)
    else $error("microprogram step out of range");

  a_ident: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.action == ACT_IDENT |=> q_r[0] == IDENT_W && q_r[1] == '0 &&
    q_r[2] == '0 && q_r[3] == '0)
    else $error("identity request did not load identity");

endmodule

// ===== dv/tb_quaternion_rotation_unit.sv =====
`timescale 1ns / 100ps

module tb_quaternion_rotation_unit;
  import qru_pkg::*;

  localparam int FB = 14;
  localparam int MAX_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  quaternion_rotation_unit #(.FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #2 clk = ~clk;

  in_t  pending_reqs[$];
  out_t expected_rows[$];
  longint orient[4];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 33;
  int recv_idle_pct = 72;
  bit hold_off = 1'b0;

  function automatic longint sat(longint v, int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // round half toward plus infinity; arithmetic shift floors
  function automatic longint rnd(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic out_t mk_row(longint a, longint b, longint c, int s, bit lst);
    out_t r;
    r.out_x = IO_W'(sat(rnd(a, s), IO_W));
    r.out_y = IO_W'(sat(rnd(b, s), IO_W));
    r.out_z = IO_W'(sat(rnd(c, s), IO_W));
    r.last = lst;
    return r;
  endfunction

  task automatic predict_request(input in_t req);
    longint ax, ay, az, qw, qx, qy, qz, ux, uy, uz, sg;
    longint dw, dx, dy, dz, tw, tx, ty, tz, rx, ry, rz, one;
    longint xx, yy, zz, xy, xz, yz, xw, yw, zw;
    ax = longint'(req.in_x); ay = longint'(req.in_y); az = longint'(req.in_z);
    qw = orient[0]; qx = orient[1]; qy = orient[2]; qz = orient[3];
    case (req.action)
      ACT_IDENT: begin
        orient[0] = sat(64'sd1 <<< FB, Q_W);
        orient[1] = 0; orient[2] = 0; orient[3] = 0;
      end
      ACT_INT: begin
        dw = -(ax * qx + ay * qy + az * qz);
        dx = qw * ax + (ay * qz - az * qy);
        dy = qw * ay + (az * qx - ax * qz);
        dz = qw * az + (ax * qy - ay * qx);
        orient[0] = sat(qw + rnd(dw, FB + 1), Q_W);
        orient[1] = sat(qx + rnd(dx, FB + 1), Q_W);
        orient[2] = sat(qy + rnd(dy, FB + 1), Q_W);
        orient[3] = sat(qz + rnd(dz, FB + 1), Q_W);
      end
      ACT_ROT, ACT_REV: begin
        sg = (req.action == ACT_ROT) ? 1 : -1;
        ux = sg * qx; uy = sg * qy; uz = sg * qz;
        tw = -(ux * ax + uy * ay + uz * az);
        tx = qw * ax + (uy * az - uz * ay);
        ty = qw * ay + (uz * ax - ux * az);
        tz = qw * az + (ux * ay - uy * ax);
        rx = -tw * ux + qw * tx - (ty * uz - tz * uy);
        ry = -tw * uy + qw * ty - (tz * ux - tx * uz);
        rz = -tw * uz + qw * tz - (tx * uy - ty * ux);
        expected_rows.push_back(mk_row(rx, ry, rz, 2 * FB, 1'b1));
      end
      ACT_MAT: begin
        one = 64'sd1 <<< (2 * FB);
        xx = 2 * qx * qx; yy = 2 * qy * qy; zz = 2 * qz * qz;
        xy = 2 * qx * qy; xz = 2 * qx * qz; yz = 2 * qy * qz;
        xw = 2 * qx * qw; yw = 2 * qy * qw; zw = 2 * qz * qw;
        expected_rows.push_back(mk_row(one - yy - zz, xy + zw, xz - yw, FB, 1'b0));
        expected_rows.push_back(mk_row(xy - zw, one - xx - zz, yz + xw, FB, 1'b0));
        expected_rows.push_back(mk_row(xz + yw, yz - xw, one - xx - yy, FB, 1'b1));
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [IO_W-1:0] rand_coord(int mode);
    case (mode)
      0: return IO_W'($urandom);
      1: return IO_W'($signed($urandom_range(0, 32768)) - 16384);
      2: return IO_W'($signed($urandom_range(0, 1024)) - 512);
      default: return IO_W'($signed($urandom_range(0, 65536)) - 32768);
    endcase
  endfunction

  function automatic in_t rand_req();
    in_t r;
    int m, p;
    p = $urandom_range(0, 99);
    if (p < 3) r.action = ACT_IDENT;
    else if (p < 35) r.action = ACT_INT;
    else if (p < 65) r.action = ACT_ROT;
    else if (p < 80) r.action = ACT_REV;
    else if (p < 96) r.action = ACT_MAT;
    else r.action = 3'($urandom_range(5, 7));
    // small increments keep the quaternion near unit length most of the time
    m = (r.action == ACT_INT) ? (($urandom_range(0, 9) == 0) ? 0 : 2)
                              : $urandom_range(0, 3);
    r.in_x = rand_coord(m);
    r.in_y = rand_coord(m);
    r.in_z = rand_coord(m);
    return r;
  endfunction

  function automatic in_t req(logic [2:0] a, int x, int y, int z);
    in_t r;
    r.action = a; r.in_x = IO_W'(x); r.in_y = IO_W'(y); r.in_z = IO_W'(z);
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_request(in_data);
      end
      if (!(in_valid && in_stall)) begin
        if (pending_reqs.size() > 0 && !hold_off &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rows.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        out_t e;
        e = expected_rows.pop_front();
        if (e !== out_data) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: exp x %0d y %0d z %0d last %b, got x %0d y %0d z %0d last %b",
                     e.out_x, e.out_y, e.out_z, e.last,
                     out_data.out_x, out_data.out_y, out_data.out_z, out_data.last);
        end
      end
    end
    if (cycles >= MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_rows.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    orient[0] = sat(64'sd1 <<< FB, Q_W);
    orient[1] = 0; orient[2] = 0; orient[3] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // directed: identity checks, field extremes, saturation, unused codes
    pending_reqs.push_back(req(ACT_MAT, 0, 0, 0));
    pending_reqs.push_back(req(ACT_ROT, 8388607, -8388608, 16384));
    pending_reqs.push_back(req(ACT_REV, -8388608, 8388607, -1));
    pending_reqs.push_back(req(ACT_INT, 8192, 0, 0));
    pending_reqs.push_back(req(ACT_ROT, 16384, 16384, 16384));
    pending_reqs.push_back(req(ACT_REV, 16384, -16384, 16384));
    pending_reqs.push_back(req(ACT_MAT, 0, 0, 0));
    pending_reqs.push_back(req(5, 8388607, 8388607, 8388607));
    pending_reqs.push_back(req(6, -1, -1, -1));
    pending_reqs.push_back(req(7, 0, 0, 0));
    pending_reqs.push_back(req(ACT_MAT, 0, 0, 0));
    pending_reqs.push_back(req(ACT_INT, 8388607, 8388607, 8388607));
    pending_reqs.push_back(req(ACT_INT, -8388608, -8388608, -8388608));
    pending_reqs.push_back(req(ACT_ROT, 8388607, 8388607, 8388607));
    pending_reqs.push_back(req(ACT_REV, -8388608, -8388608, -8388608));
    pending_reqs.push_back(req(ACT_MAT, 0, 0, 0));
    pending_reqs.push_back(req(ACT_IDENT, -1, -1, -1));
    pending_reqs.push_back(req(ACT_INT, 0, -8192, 8192));
    pending_reqs.push_back(req(ACT_MAT, 0, 0, 0));
    pending_reqs.push_back(req(ACT_IDENT, 0, 0, 0));
    wait_drained();
    // pause the driver once everything expected has arrived
    hold_off = 1'b1;
    repeat (40) @(posedge clk);
    hold_off = 1'b0;
    for (int i = 0; i < 170; i++) pending_reqs.push_back(rand_req());
    wait_drained();
    send_idle_pct = 72; recv_idle_pct = 33;
    for (int i = 0; i < 170; i++) pending_reqs.push_back(rand_req());
    wait_drained();
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < 5; i++) pending_reqs.push_back(req(ACT_MAT, 0, 0, 0));
    for (int i = 0; i < 160; i++) pending_reqs.push_back(rand_req());
    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
